// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for concurrent assertions; compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication, disabled during reset
`define AST_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled during reset
`define AST_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define AST_IMPL(lbl, clk, rstn, ante, cons)
`define AST_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ===== hdl/pce_pkg.sv =====
// ----------------------------------------------------------------------------
// Palette channel editor package
// Geometry, command and channel codes, wave shapes, result item type and fill function.
// ----------------------------------------------------------------------------
package pce_pkg;

    // palette geometry
    localparam int C_ENTRIES    = 30;
    localparam int C_IDX_W      = 5;
    localparam int C_LVL_W      = 4;
    localparam int C_MAX_LEVEL  = 15;
    localparam int C_SAW_PERIOD = 10;
    localparam int C_TRI_CLIP   = 10;

    // commands
    localparam logic [2:0] CMD_LOAD  = 3'd0;
    localparam logic [2:0] CMD_ROT_L = 3'd1;
    localparam logic [2:0] CMD_ROT_R = 3'd2;
    localparam logic [2:0] CMD_INC   = 3'd3;
    localparam logic [2:0] CMD_DEC   = 3'd4;
    localparam logic [2:0] CMD_FILL  = 3'd5;

    // channel select
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    // wave numbers within a set
    localparam logic [2:0] WV_RAMP  = 3'd0;
    localparam logic [2:0] WV_TRI   = 3'd1;
    localparam logic [2:0] WV_FALL  = 3'd2;
    localparam logic [2:0] WV_SAW   = 3'd3;
    localparam logic [2:0] WV_EXTRA = 3'd4;

    // one palette entry: blue, green, red from the top down
    typedef logic [3*C_LVL_W-1:0] t_rgb;

    typedef struct packed {
        logic                 last;
        t_rgb                 rgb;
        logic [C_IDX_W-1:0]   idx;
    } t_out_item;

    // fill value of one entry
    function automatic logic [C_LVL_W-1:0] wave_value(
        input logic               set,
        input logic [2:0]         pat,
        input logic [C_IDX_W-1:0] idx
    );
        logic [C_IDX_W-1:0] rev;
        logic [C_IDX_W-1:0] tri_v;
        logic [C_IDX_W-1:0] m10;
        logic [C_IDX_W-1:0] m15;
        logic [C_IDX_W-1:0] v;
        rev   = C_IDX_W'(C_ENTRIES) - idx;
        tri_v = (idx < C_IDX_W'(C_MAX_LEVEL)) ? idx : rev;
        if (idx < C_IDX_W'(C_SAW_PERIOD))
            m10 = idx;
        else if (idx < C_IDX_W'(2 * C_SAW_PERIOD))
            m10 = idx - C_IDX_W'(C_SAW_PERIOD);
        else
            m10 = idx - C_IDX_W'(2 * C_SAW_PERIOD);
        if (idx < C_IDX_W'(C_MAX_LEVEL))
            m15 = idx;
        else if (idx < C_IDX_W'(2 * C_MAX_LEVEL))
            m15 = idx - C_IDX_W'(C_MAX_LEVEL);
        else
            m15 = idx - C_IDX_W'(2 * C_MAX_LEVEL);
        v = '0;
        if (!set) begin
            case (pat)
                WV_RAMP: v = idx >> 1;
                WV_TRI:  v = tri_v;
                WV_FALL: v = C_IDX_W'(C_MAX_LEVEL) - (idx >> 1);
                WV_SAW:  v = m10;
                default: v = '0;
            endcase
        end else begin
            case (pat)
                WV_RAMP:  v = (idx > C_IDX_W'(C_MAX_LEVEL)) ? C_IDX_W'(C_MAX_LEVEL) : idx;
                WV_TRI:   v = (tri_v > C_IDX_W'(C_TRI_CLIP)) ? C_IDX_W'(C_TRI_CLIP) : tri_v;
                WV_FALL:  v = (rev > C_IDX_W'(C_MAX_LEVEL)) ? C_IDX_W'(C_MAX_LEVEL) : rev;
                WV_SAW:   v = m15;
                WV_EXTRA: v = C_IDX_W'(C_MAX_LEVEL) - m15;
                default:  v = '0;
            endcase
        end
        return v[C_LVL_W-1:0];
    endfunction

endpackage

// ===== hdl/palette_channel_editor.sv =====
// ----------------------------------------------------------------------------
// Palette channel editor
// Palette of red/green/blue levels held in one synchronous RAM, edited by
// read-modify-write sweeps and dumped in index order after each known command.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one command per request (cmd in tuser, operands in tdata).
//   m_axis returns the whole palette after every known command, one entry per
//   request in index order, tlast on the final entry. Unknown commands are
//   taken and dropped without output.
//   A load writes the RAM in the cycle it is taken, so the dump starts at
//   once. Rotate, increment, decrement and fill first sweep the RAM (30
//   reads, a wait for the registered read, and for a rotate one wrap-around
//   write), then dump. The single read port of the palette RAM is why the
//   sweep and the dump run one after the other.
//   s_axis_tready is high only between commands. A two-deep output queue
//   with read credit lets the dump run at one entry per cycle and pause
//   cleanly when m_axis_tready is low; the next command may be taken while
//   the queue still drains.
//   Reset empties the queue and marks every entry unwritten; an unwritten
//   entry reads as zero, so the palette starts all black with no clearing
//   pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module palette_channel_editor
    import pce_pkg::*;
#(
    parameter int ENTRIES = C_ENTRIES
)(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // s_axis_tdata: entry_index[4:0], load_red[8:5], load_green[12:9],
    //   load_blue[16:13], channel_mask[19:17], channel[21:20],
    //   wave_set[22], pattern[25:23], zero fill above
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,
    // s_axis_tuser: cmd[2:0]
    input  logic [2:0]  s_axis_tuser,
    // m_axis_tdata: out_index[4:0], out_red[8:5], out_green[12:9],
    //   out_blue[16:13], zero fill above
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,
    output logic        m_axis_tlast
);

    localparam int SW = $clog2(ENTRIES + 2);
    localparam int CW = $clog2(ENTRIES + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EDIT = 2'd1;
    localparam logic [1:0] ST_DUMP = 2'd2;

    // request fields
    logic [C_IDX_W-1:0] in_idx;
    t_rgb               in_rgb;
    logic [2:0]         in_mask;
    logic [1:0]         in_ch;
    logic               in_set;
    logic [2:0]         in_pat;
    logic               s_acc;

    assign in_idx  = s_axis_tdata[4:0];
    assign in_rgb  = s_axis_tdata[16:5];
    assign in_mask = s_axis_tdata[19:17];
    assign in_ch   = s_axis_tdata[21:20];
    assign in_set  = s_axis_tdata[22];
    assign in_pat  = s_axis_tdata[25:23];
    assign s_acc   = s_axis_tvalid && s_axis_tready;

    // control and captured command
    logic [1:0]         r_state, n_state;
    logic [2:0]         r_cmd;
    logic [2:0]         r_mask;
    logic [1:0]         r_ch;
    logic               r_set;
    logic [2:0]         r_pat;
    logic [SW-1:0]      r_step;
    logic [CW-1:0]      r_dcnt;

    // palette RAM and its read side
    t_rgb               r_mem [ENTRIES];
    logic [ENTRIES-1:0] r_valid;
    t_rgb               r_rd_data;
    logic               r_rd_vld;
    logic [C_IDX_W-1:0] r_raddr;
    logic               rd_en;
    logic [C_IDX_W-1:0] rd_addr;
    t_rgb               d_cur;
    logic               we;
    logic [C_IDX_W-1:0] waddr;
    t_rgb               wdata;

    // sweep pipeline
    logic [C_IDX_W-1:0] r_paddr;
    t_rgb               r_prev;
    t_rgb               r_first;
    logic               is_rot;
    logic               ed_dv;
    logic               ed_tail;
    t_rgb               edit_val;
    t_rgb               mix_val;
    t_rgb               mix_src;
    logic [C_LVL_W-1:0] sel_lvl;
    logic [C_LVL_W-1:0] new_lvl;

    // output queue
    t_out_item          r_q [2];
    logic               r_wp;
    logic               r_rp;
    logic [1:0]         r_cnt, n_cnt;
    logic               r_pend;
    logic               pop;
    logic               dump_issue;
    t_out_item          o_item;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign d_cur         = r_rd_vld ? r_rd_data : '0;
    assign is_rot        = (r_cmd == CMD_ROT_L) || (r_cmd == CMD_ROT_R);
    assign ed_dv   = (r_state == ST_EDIT) && (r_step != '0) && (r_step <= SW'(ENTRIES));
    assign ed_tail = (r_state == ST_EDIT) && (r_step == SW'(ENTRIES + 1));

    // read credit: at most two entries queued or in flight
    assign pop        = (r_cnt != 2'd0) && m_axis_tready;
    assign dump_issue = (r_state == ST_DUMP) && (r_dcnt < CW'(ENTRIES)) &&
                        (((r_cnt + 2'(r_pend)) < 2'd2) || pop);

    // read address: rotate right sweeps downwards, everything else upwards
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = '0;
        if ((r_state == ST_EDIT) && (r_step < SW'(ENTRIES))) begin
            rd_en = 1'b1;
            if (r_cmd == CMD_ROT_R)
                rd_addr = C_IDX_W'(ENTRIES - 1) - r_step[C_IDX_W-1:0];
            else
                rd_addr = r_step[C_IDX_W-1:0];
        end else if (dump_issue) begin
            rd_en   = 1'b1;
            rd_addr = r_dcnt[C_IDX_W-1:0];
        end
    end

    // increment, decrement or fill of the chosen channel
    always_comb begin
        case (r_ch)
            CH_RED:   sel_lvl = d_cur[3:0];
            CH_GREEN: sel_lvl = d_cur[7:4];
            CH_BLUE:  sel_lvl = d_cur[11:8];
            default:  sel_lvl = '0;
        endcase
        case (r_cmd)
            CMD_INC: new_lvl = sel_lvl + 4'd1;
            CMD_DEC: new_lvl = sel_lvl - 4'd1;
            default: new_lvl = wave_value(r_set, r_pat, r_raddr);
        endcase
        edit_val = d_cur;
        case (r_ch)
            CH_RED:   edit_val[3:0]  = new_lvl;
            CH_GREEN: edit_val[7:4]  = new_lvl;
            CH_BLUE:  edit_val[11:8] = new_lvl;
            default:  ;
        endcase
    end

    // rotate: masked channels from the neighbour, the rest kept
    always_comb begin
        mix_src = ed_tail ? r_first : d_cur;
        for (int c = 0; c < 3; c++) begin
            mix_val[c*C_LVL_W +: C_LVL_W] = r_mask[c] ? mix_src[c*C_LVL_W +: C_LVL_W]
                                                      : r_prev[c*C_LVL_W +: C_LVL_W];
        end
    end

    // RAM write port
    always_comb begin
        we    = 1'b0;
        waddr = '0;
        wdata = '0;
        if (s_acc && (s_axis_tuser == CMD_LOAD) && (in_idx < C_IDX_W'(ENTRIES))) begin
            we    = 1'b1;
            waddr = in_idx;
            wdata = in_rgb;
        end else if (ed_dv && !is_rot) begin
            we    = 1'b1;
            waddr = r_raddr;
            wdata = edit_val;
        end else if ((ed_dv && (r_step >= SW'(2)) && is_rot) || (ed_tail && is_rot)) begin
            we    = 1'b1;
            waddr = r_paddr;
            wdata = mix_val;
        end
    end

    // palette RAM, registered read
    always_ff @(posedge i_clk) begin
        if (we)
            r_mem[waddr] <= wdata;
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
            r_rd_vld  <= r_valid[rd_addr];
            r_raddr   <= rd_addr;
        end
    end

    // written marks, all clear after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_valid <= '0;
        else if (we)
            r_valid[waddr] <= 1'b1;
    end

    // sweep history for rotation
    always_ff @(posedge i_clk) begin
        if (ed_dv) begin
            r_prev  <= d_cur;
            r_paddr <= r_raddr;
            if (r_step == SW'(1))
                r_first <= d_cur;
        end
    end

    // command capture
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_cmd  <= s_axis_tuser;
            r_mask <= in_mask;
            r_ch   <= in_ch;
            r_set  <= in_set;
            r_pat  <= in_pat;
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (s_acc) begin
                    unique case (s_axis_tuser) inside
                        CMD_LOAD: n_state = ST_DUMP;
                        CMD_ROT_L, CMD_ROT_R, CMD_INC, CMD_DEC, CMD_FILL:
                            n_state = ST_EDIT;
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_EDIT: begin
                if (ed_tail)
                    n_state = ST_DUMP;
            end
            ST_DUMP: begin
                if (r_dcnt == CW'(ENTRIES))
                    n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
            r_dcnt  <= '0;
        end else begin
            r_state <= n_state;
            if (s_acc) begin
                r_step <= '0;
                r_dcnt <= '0;
            end else begin
                if (r_state == ST_EDIT)
                    r_step <= r_step + SW'(1);
                if (dump_issue)
                    r_dcnt <= r_dcnt + CW'(1);
            end
        end
    end

    // output queue: landed reads in, accepted requests out
    assign n_cnt = r_cnt + 2'(r_pend) - 2'(pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
            r_cnt  <= '0;
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
        end else begin
            r_pend <= dump_issue;
            r_cnt  <= n_cnt;
            if (r_pend)
                r_wp <= ~r_wp;
            if (pop)
                r_rp <= ~r_rp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_pend) begin
            r_q[r_wp].idx  <= r_raddr;
            r_q[r_wp].rgb  <= d_cur;
            r_q[r_wp].last <= (r_raddr == C_IDX_W'(ENTRIES - 1));
        end
    end

    assign o_item        = r_q[r_rp];
    assign m_axis_tvalid = (r_cnt != 2'd0);
    assign m_axis_tdata  = {7'd0, o_item.rgb, o_item.idx};
    assign m_axis_tlast  = o_item.last;

    // checks
    `AST_IMPL(a_credit, i_clk, i_rst_n, 1'b1, (r_cnt + 2'(r_pend)) <= 2'd2)
    `AST_IMPL(a_last_idx, i_clk, i_rst_n, m_axis_tvalid && m_axis_tlast, m_axis_tdata[4:0] == C_IDX_W'(ENTRIES - 1))
    `AST_NEXT(a_cmd_runs, i_clk, i_rst_n, s_acc && (s_axis_tuser <= CMD_FILL), r_state != ST_IDLE)
    `AST_IMPL(a_wr_range, i_clk, i_rst_n, we, waddr < C_IDX_W'(ENTRIES))

endmodule
